[hdl/three_phase_frequency_monitor_assert.svh]
// Assertion macros shared by the frequency monitor checker.
`ifndef THREE_PHASE_FREQUENCY_MONITOR_ASSERT_SVH
`define THREE_PHASE_FREQUENCY_MONITOR_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define TPFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frequency monitor assertion failed");

// Check the consequent in the cycle after the antecedent.
`define TPFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frequency monitor assertion failed");

`endif

[hdl/tpfm_pkg.sv]
// Types, constants and codes shared by the frequency monitor modules.
`default_nettype none
package tpfm_pkg;

   localparam int PHASE_COUNT = 3;
   localparam int PHASE_IDX_W = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;

   localparam int STAMP_W   = 16;
   localparam int FREQ_W    = 20;
   localparam int TIMEOUT_W = 8;

   // one quotient bit per divider step
   localparam int DIV_STEPS = FREQ_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = FREQ_W;

   typedef logic [STAMP_W-1:0]     stamp_type;
   typedef logic [FREQ_W-1:0]      freq_type;
   typedef logic [TIMEOUT_W-1:0]   timeout_type;
   typedef logic [PHASE_IDX_W-1:0] phase_idx_type;
   typedef logic [STEP_W-1:0]      step_type;
   typedef logic [CSR_INDEX_W-1:0] csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_idx_type CSR_TICK_RATE       = 1'b0;
   localparam csr_idx_type CSR_WATCHDOG_RELOAD = 1'b1;

   localparam freq_type    TICK_RATE_RESET       = FREQ_W'(100000);
   localparam timeout_type WATCHDOG_RELOAD_RESET = TIMEOUT_W'(10);

   localparam phase_idx_type PHASE_LAST = PHASE_IDX_W'(PHASE_COUNT - 1);
   localparam step_type      STEP_LAST  = STEP_W'(DIV_STEPS - 1);

   // commands from the controller to the datapath
   typedef struct packed {
      logic          load;
      logic          div_load;
      logic          div_step;
      logic          commit_fresh;
      logic          commit_stale;
      logic          publish;
      phase_idx_type phase;
   } cmd_type;

   typedef struct packed {
      logic fresh;
   } status_type;

endpackage
`default_nettype wire

[hdl/tpfm_channels.sv]
// Request and response channel interfaces of the frequency monitor.
`default_nettype none
interface tpfm_req_if import tpfm_pkg::*; ();
   logic      valid;
   logic      ready;
   stamp_type phase_a_first;
   stamp_type phase_a_second;
   stamp_type phase_b_first;
   stamp_type phase_b_second;
   stamp_type phase_c_first;
   stamp_type phase_c_second;

   modport source (output valid, output phase_a_first, output phase_a_second,
                   output phase_b_first, output phase_b_second,
                   output phase_c_first, output phase_c_second, input ready);
   modport sink (input valid, input phase_a_first, input phase_a_second,
                 input phase_b_first, input phase_b_second,
                 input phase_c_first, input phase_c_second, output ready);
endinterface

interface tpfm_rsp_if import tpfm_pkg::*; ();
   logic        valid;
   logic        ready;
   freq_type    freq_a;
   freq_type    freq_b;
   freq_type    freq_c;
   stamp_type   period_a_out;
   stamp_type   period_b_out;
   stamp_type   period_c_out;
   timeout_type timeout_a;
   timeout_type timeout_b;
   timeout_type timeout_c;
   logic        fail_a;
   logic        fail_b;
   logic        fail_c;

   modport source (output valid, output freq_a, output freq_b, output freq_c,
                   output period_a_out, output period_b_out, output period_c_out,
                   output timeout_a, output timeout_b, output timeout_c,
                   output fail_a, output fail_b, output fail_c, input ready);
   modport sink (input valid, input freq_a, input freq_b, input freq_c,
                 input period_a_out, input period_b_out, input period_c_out,
                 input timeout_a, input timeout_b, input timeout_c,
                 input fail_a, input fail_b, input fail_c, output ready);
endinterface
`default_nettype wire

[hdl/tpfm_datapath.sv]
// Datapath: capture registers, serial divider, per-phase state, response register.
`default_nettype none
module tpfm_datapath import tpfm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output status_type        status,
   input  wire logic         csr_we,
   input  wire csr_idx_type  csr_index,
   input  wire csr_data_type csr_wdata,
   input  wire stamp_type    req_first [PHASE_COUNT],
   input  wire stamp_type    req_second [PHASE_COUNT],
   output freq_type          out_freq [PHASE_COUNT],
   output stamp_type         out_period [PHASE_COUNT],
   output timeout_type       out_timeout [PHASE_COUNT],
   output logic              out_fail [PHASE_COUNT]
);

   freq_type    tick_rate_ff;
   timeout_type wd_reload_ff;

   stamp_type first_ff [PHASE_COUNT];
   stamp_type second_ff [PHASE_COUNT];

   stamp_type   held_period_ff [PHASE_COUNT];
   freq_type    held_freq_ff [PHASE_COUNT];
   timeout_type wd_count_ff [PHASE_COUNT];

   freq_type    rsp_freq_ff [PHASE_COUNT];
   stamp_type   rsp_period_ff [PHASE_COUNT];
   timeout_type rsp_timeout_ff [PHASE_COUNT];
   logic        rsp_fail_ff [PHASE_COUNT];

   stamp_type divisor_ff, divisor_in;
   stamp_type rem_ff, rem_in;
   freq_type  quo_ff, quo_in;

   stamp_type             sel_first;
   stamp_type             sel_second;
   logic [STAMP_W:0]      rem_shift;
   logic [STAMP_W+1:0]    trial;
   logic                  trial_ge;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
         wd_reload_ff <= WATCHDOG_RELOAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICK_RATE:       tick_rate_ff <= csr_wdata;
            CSR_WATCHDOG_RELOAD: wd_reload_ff <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff  <= req_first;
         second_ff <= req_second;
      end
   end

   assign sel_first    = first_ff[cmd.phase];
   assign sel_second   = second_ff[cmd.phase];
   assign status.fresh = sel_second > sel_first;

   // restoring divider, one quotient bit a step
   assign rem_shift = {rem_ff, quo_ff[FREQ_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign trial_ge  = ~trial[STAMP_W+1];

   always_comb begin
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (cmd.div_load) begin
         divisor_in = sel_second - sel_first;
         rem_in     = '0;
         quo_in     = tick_rate_ff;
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? trial[STAMP_W-1:0] : rem_shift[STAMP_W-1:0];
         quo_in = {quo_ff[FREQ_W-2:0], trial_ge};
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   // per-phase held state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PHASE_COUNT; p++) begin
            held_period_ff[p] <= '0;
            held_freq_ff[p]   <= '0;
            wd_count_ff[p]    <= '0;
         end
      end else if (cmd.commit_fresh) begin
         held_period_ff[cmd.phase] <= divisor_ff;
         held_freq_ff[cmd.phase]   <= quo_ff;
         wd_count_ff[cmd.phase]    <= wd_reload_ff;
      end else if (cmd.commit_stale && (wd_count_ff[cmd.phase] != '0)) begin
         wd_count_ff[cmd.phase] <= wd_count_ff[cmd.phase] - 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         for (int p = 0; p < PHASE_COUNT; p++) begin
            rsp_freq_ff[p]    <= held_freq_ff[p];
            rsp_period_ff[p]  <= held_period_ff[p];
            rsp_timeout_ff[p] <= wd_count_ff[p];
            rsp_fail_ff[p]    <= (wd_count_ff[p] == '0);
         end
      end
   end

   assign out_freq    = rsp_freq_ff;
   assign out_period  = rsp_period_ff;
   assign out_timeout = rsp_timeout_ff;
   assign out_fail    = rsp_fail_ff;

endmodule
`default_nettype wire

[hdl/tpfm_controller.sv]
// Controller: sequences phases through the shared divider and hands off the response.
`default_nettype none
module tpfm_controller import tpfm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   phase_idx_type phase_ff, phase_in;
   step_type      step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.phase    = phase_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               phase_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.fresh) begin
               cmd.div_load = 1'b1;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end else begin
               cmd.commit_stale = 1'b1;
               if (phase_ff == PHASE_LAST) begin
                  state_in = ST_FINISH;
               end else begin
                  phase_in = phase_ff + 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit_fresh = 1'b1;
            if (phase_ff == PHASE_LAST) begin
               state_in = ST_FINISH;
            end else begin
               phase_in = phase_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // wait for the response register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[hdl/three_phase_frequency_monitor.sv]
// Top level of the three-phase frequency monitor.
// After acceptance each phase is handled in turn: a phase with no fresh capture only
// counts its watchdog down, one with a fresh capture runs the 20-step shared divider and
// commits the result; the response register is then loaded once it is free.
// A new request is accepted only once the last one is loaded into the response register.
// Reset (synchronous): tick_rate 100000, watchdog_reload 10, held values and watchdogs zero.
`default_nettype none
module three_phase_frequency_monitor import tpfm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   tpfm_req_if.sink          req_if,
   tpfm_rsp_if.source        rsp_if,
   input  wire logic         csr_we,
   input  wire csr_idx_type  csr_index,
   input  wire csr_data_type csr_wdata
);

   cmd_type    cmd;
   status_type status;

   stamp_type   req_first [PHASE_COUNT];
   stamp_type   req_second [PHASE_COUNT];
   freq_type    out_freq [PHASE_COUNT];
   stamp_type   out_period [PHASE_COUNT];
   timeout_type out_timeout [PHASE_COUNT];
   logic        out_fail [PHASE_COUNT];

   // gather the request fields into per-phase arrays
   assign req_first[0]  = req_if.phase_a_first;
   assign req_second[0] = req_if.phase_a_second;
   assign req_first[1]  = req_if.phase_b_first;
   assign req_second[1] = req_if.phase_b_second;
   assign req_first[2]  = req_if.phase_c_first;
   assign req_second[2] = req_if.phase_c_second;

   // the controller walks the phases one after another and drives the handshake
   tpfm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // the datapath holds the configuration, per-phase state and the response register,
   // so a finished response can wait while the next request is accepted
   tpfm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_first   (req_first),
      .req_second  (req_second),
      .out_freq    (out_freq),
      .out_period  (out_period),
      .out_timeout (out_timeout),
      .out_fail    (out_fail)
   );

   // scatter the response arrays onto the channel
   assign rsp_if.freq_a       = out_freq[0];
   assign rsp_if.freq_b       = out_freq[1];
   assign rsp_if.freq_c       = out_freq[2];
   assign rsp_if.period_a_out = out_period[0];
   assign rsp_if.period_b_out = out_period[1];
   assign rsp_if.period_c_out = out_period[2];
   assign rsp_if.timeout_a    = out_timeout[0];
   assign rsp_if.timeout_b    = out_timeout[1];
   assign rsp_if.timeout_c    = out_timeout[2];
   assign rsp_if.fail_a       = out_fail[0];
   assign rsp_if.fail_b       = out_fail[1];
   assign rsp_if.fail_c       = out_fail[2];

endmodule
`default_nettype wire

[hdl/tpfm_checker.sv]
// Port-level checker for the frequency monitor and its bind.
`default_nettype none
`include "three_phase_frequency_monitor_assert.svh"
module tpfm_checker import tpfm_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire timeout_type timeout_a,
   input wire timeout_type timeout_b,
   input wire timeout_type timeout_c,
   input wire logic        fail_a,
   input wire logic        fail_b,
   input wire logic        fail_c
);

   logic                   rsp_held;
   logic [3*TIMEOUT_W-1:0] wd_all;
   logic                   fail_ok;

   assign rsp_held = rsp_valid && !rsp_ready;
   assign wd_all   = {timeout_a, timeout_b, timeout_c};
   assign fail_ok  = (fail_a == (timeout_a == '0)) && (fail_b == (timeout_b == '0)) &&
                     (fail_c == (timeout_c == '0));

   `TPFM_ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_held, rsp_valid)
   `TPFM_ASSERT_NEXT(rsp_watchdog_stable, clock, reset, rsp_held, $stable(wd_all))
   `TPFM_ASSERT_NOW(fail_tracks_watchdog, clock, reset, rsp_valid, fail_ok)
   `TPFM_ASSERT_NEXT(busy_after_request, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind three_phase_frequency_monitor tpfm_checker u_tpfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .timeout_a (rsp_if.timeout_a),
   .timeout_b (rsp_if.timeout_b),
   .timeout_c (rsp_if.timeout_c),
   .fail_a    (rsp_if.fail_a),
   .fail_b    (rsp_if.fail_b),
   .fail_c    (rsp_if.fail_c)
);
`default_nettype wire

[verif/tb_top.sv]
// Testbench for the three-phase frequency monitor: directed and random capture traffic.
`default_nettype none
module tb_top;
   import tpfm_pkg::*;

   // one update tick worth of capture timestamps, index 0 is phase A
   typedef struct packed {
      stamp_type [PHASE_COUNT-1:0] first;
      stamp_type [PHASE_COUNT-1:0] second;
   } capture_set_type;

   // what the block publishes after each tick
   typedef struct packed {
      freq_type    [PHASE_COUNT-1:0] freq;
      stamp_type   [PHASE_COUNT-1:0] period;
      timeout_type [PHASE_COUNT-1:0] watchdog;
      logic        [PHASE_COUNT-1:0] fail;
   } reading_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_we;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   tpfm_req_if req_ch ();
   tpfm_rsp_if rsp_ch ();

   three_phase_frequency_monitor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mirror of the monitor's registers and per-phase state.
   freq_type    tick_rate_cfg;
   timeout_type reload_cfg;
   stamp_type   held_period   [PHASE_COUNT];
   freq_type    held_freq     [PHASE_COUNT];
   timeout_type watchdog_left [PHASE_COUNT];

   reading_type predicted_readings [$];

   int  mismatch_count = 0;
   int  request_count  = 0;
   int  response_count = 0;
   int  write_count    = 0;
   bit  burst_mode     = 1'b0;  // when set, neither side idles

   // Advance the mirrored state by one update tick and return the reading it publishes.
   function automatic reading_type advance_monitor(capture_set_type caps);
      reading_type r;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (caps.second[p] > caps.first[p]) begin
            // fresh capture: latch period, divide, reload the watchdog
            held_period[p]   = caps.second[p] - caps.first[p];
            held_freq[p]     = tick_rate_cfg / held_period[p];
            watchdog_left[p] = reload_cfg;
         end else if (watchdog_left[p] != '0) begin
            // no capture: count down and stick at zero
            watchdog_left[p] = watchdog_left[p] - 1'b1;
         end
         r.freq[p]     = held_freq[p];
         r.period[p]   = held_period[p];
         r.watchdog[p] = watchdog_left[p];
         r.fail[p]     = (watchdog_left[p] == '0);
      end
      return r;
   endfunction

   function automatic int draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic capture_set_type make_set(stamp_type fa, stamp_type sa, stamp_type fb,
                                                stamp_type sb, stamp_type fc, stamp_type sc);
      capture_set_type c;
      c.first[0] = fa; c.second[0] = sa;
      c.first[1] = fb; c.second[1] = sb;
      c.first[2] = fc; c.second[2] = sc;
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Present one request after a random gap, hold it until accepted, then log its reading.
   task automatic send_capture(input capture_set_type caps);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.phase_a_first  <= caps.first[0];
      req_ch.phase_a_second <= caps.second[0];
      req_ch.phase_b_first  <= caps.first[1];
      req_ch.phase_b_second <= caps.second[1];
      req_ch.phase_c_first  <= caps.first[2];
      req_ch.phase_c_second <= caps.second[2];
      req_ch.valid          <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // leave valid high: the next call drops it only if it idles
      predicted_readings.push_back(advance_monitor(caps));
      request_count++;
   endtask

   // Drop valid and hold until every pending reading has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (predicted_readings.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_register(input csr_idx_type idx, input csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_TICK_RATE)
         tick_rate_cfg = data;
      else if (idx == CSR_WATCHDOG_RELOAD)
         reload_cfg = data[TIMEOUT_W-1:0];
      write_count++;
   endtask

   // Draw stamps for one phase: a forward pair when fresh, else equal or backward.
   task automatic draw_phase(input bit fresh, output stamp_type first, output stamp_type second);
      int span;
      if (fresh) begin
         case ($urandom_range(0, 3))
            0: span = $urandom_range(1, 16);
            1: span = $urandom_range(17, 4095);
            2: span = $urandom_range(4096, 65535);
            default: span = $urandom_range(1, 65535);
         endcase
         first  = 16'($urandom_range(0, 65535 - span));
         second = 16'(first + span);
      end else begin
         first  = 16'($urandom_range(0, 65535));
         second = 16'($urandom_range(0, first));
      end
   endtask

   // ---------------------------------------------------------------- response side
   // Stall ready for a random number of cycles before each response.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
      end
   end

   reading_type got_reading, want_reading;

   // Compare every accepted response against the oldest pending reading.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         response_count++;
         got_reading.freq     = {rsp_ch.freq_c, rsp_ch.freq_b, rsp_ch.freq_a};
         got_reading.period   = {rsp_ch.period_c_out, rsp_ch.period_b_out, rsp_ch.period_a_out};
         got_reading.watchdog = {rsp_ch.timeout_c, rsp_ch.timeout_b, rsp_ch.timeout_a};
         got_reading.fail     = {rsp_ch.fail_c, rsp_ch.fail_b, rsp_ch.fail_a};
         if (predicted_readings.size() == 0) begin
            report_mismatch("response with no request pending");
         end else begin
            want_reading = predicted_readings.pop_front();
            for (int p = 0; p < PHASE_COUNT; p++) begin
               if (got_reading.freq[p] !== want_reading.freq[p])
                  report_mismatch($sformatf("phase %c freq got %0d want %0d", 8'd65 + p,
                                            got_reading.freq[p], want_reading.freq[p]));
               if (got_reading.period[p] !== want_reading.period[p])
                  report_mismatch($sformatf("phase %c period got %0d want %0d", 8'd65 + p,
                                            got_reading.period[p], want_reading.period[p]));
               if (got_reading.watchdog[p] !== want_reading.watchdog[p])
                  report_mismatch($sformatf("phase %c timeout got %0d want %0d", 8'd65 + p,
                                            got_reading.watchdog[p],
                                            want_reading.watchdog[p]));
               if (got_reading.fail[p] !== want_reading.fail[p])
                  report_mismatch($sformatf("phase %c fail got %b want %b", 8'd65 + p,
                                            got_reading.fail[p], want_reading.fail[p]));
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Right after reset every watchdog is zero, so all phases read failed.
   task automatic test_reset_state();
      send_capture(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      // A gets the shortest period, B equal stamps, C a backward pair
      send_capture(make_set(16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
      // full-span period on every phase
      send_capture(make_set(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
   endtask

   // Drive the dividend and reload to their extremes, plus a zero dividend.
   task automatic test_register_extremes();
      drain();
      write_register(CSR_TICK_RATE, 20'hFFFFF);
      send_capture(make_set(16'h1000, 16'h1001, 16'h0000, 16'h0002, 16'hFFFE, 16'hFFFF));
      send_capture(make_set(16'h0000, 16'hFFFF, 16'h0003, 16'h0002, 16'h0100, 16'h0200));
      drain();
      write_register(CSR_TICK_RATE, 20'd1);
      send_capture(make_set(16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'h8000, 16'h8000));
      drain();
      write_register(CSR_TICK_RATE, 20'd0);
      send_capture(make_set(16'h0010, 16'h0017, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF));
      drain();
      // reload of zero with junk above the field: fails even while capturing
      write_register(CSR_TICK_RATE, TICK_RATE_RESET);
      write_register(CSR_WATCHDOG_RELOAD, 20'hFFF00);
      send_capture(make_set(16'h0000, 16'h0064, 16'h1234, 16'h5678, 16'h0001, 16'h0002));
      drain();
      write_register(CSR_WATCHDOG_RELOAD, 20'hFFFFF);
      send_capture(make_set(16'h0000, 16'h0064, 16'h1234, 16'h5678, 16'h0001, 16'h0002));
      send_capture(make_set(16'h0064, 16'h0064, 16'h5678, 16'h1234, 16'h0002, 16'h0001));
   endtask

   // Let the watchdog run out and stick at zero, then recover one phase.
   task automatic test_watchdog_countdown();
      drain();
      write_register(CSR_WATCHDOG_RELOAD, 20'd3);
      send_capture(make_set(16'h0000, 16'h03E8, 16'h0010, 16'h07D0, 16'h0000, 16'h0001));
      repeat (4)
         send_capture(make_set(16'h0500, 16'h0500, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000));
      send_capture(make_set(16'h0000, 16'h0002, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
   endtask

   // Mostly healthy captures with phases dropping out for runs of ticks, over many settings.
   task automatic test_random_traffic();
      bit              dropped [PHASE_COUNT];
      capture_set_type caps;
      bit              fresh;
      stamp_type       f, s;
      freq_type        rate;
      timeout_type     reload;
      for (int p = 0; p < PHASE_COUNT; p++) dropped[p] = 1'b0;
      for (int setting = 0; setting < 10; setting++) begin
         drain();
         case (setting)
            0: begin rate = 20'hFFFFF; reload = 8'd255; end
            1: begin rate = 20'd1;     reload = 8'd0;   end
            default: begin
               rate   = ($urandom_range(0, 1) != 0) ? 20'($urandom_range(1, 20'hFFFFF))
                                                    : 20'($urandom_range(1, 2000));
               reload = 8'($urandom_range(0, 8));
            end
         endcase
         write_register(CSR_TICK_RATE, rate);
         write_register(CSR_WATCHDOG_RELOAD, {12'($urandom_range(0, 4095)), reload});
         // run two of the settings with no idling on either side
         burst_mode = (setting == 3 || setting == 7);
         for (int i = 0; i < 190; i++) begin
            // hold the sender until everything is back, midway through each setting
            if (i == 95) drain();
            for (int p = 0; p < PHASE_COUNT; p++) begin
               if ($urandom_range(0, 15) == 0) dropped[p] = ~dropped[p];
               fresh = dropped[p] ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 99) < 85);
               draw_phase(fresh, f, s);
               caps.first[p]  = f;
               caps.second[p] = s;
            end
            send_capture(caps);
         end
      end
      burst_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_TICK_RATE;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.phase_a_first  <= '0;
      req_ch.phase_a_second <= '0;
      req_ch.phase_b_first  <= '0;
      req_ch.phase_b_second <= '0;
      req_ch.phase_c_first  <= '0;
      req_ch.phase_c_second <= '0;
      tick_rate_cfg = TICK_RATE_RESET;
      reload_cfg    = WATCHDOG_RELOAD_RESET;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         held_period[p]   = '0;
         held_freq[p]     = '0;
         watchdog_left[p] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_extremes();
      test_watchdog_countdown();
      test_random_traffic();

      drain();
      // give a stray extra response time to show up
      repeat (70) @(posedge clock);
      if (predicted_readings.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", predicted_readings.size()));

      $display("Run covered %0d requests and %0d register writes; %0d responses checked.",
               request_count, write_count, response_count);
      $display("Dividend and reload extremes, watchdog expiry and idle-free bursts exercised.");
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #12_000_000;
      $display("Run timed out with %0d responses pending.", predicted_readings.size());
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
`default_nettype wire
